[rtl/mandelbrot_escape_time_pixel_core_defines.svh]
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel core - assertion macros
// Shared concurrent assertion forms for the pixel core.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_CORE_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_CORE_DEFINES_SVH

// same-cycle implication
`define MBET_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MBET_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/mbet_pkg.sv]
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel core - package
// Widths, register codes, sequencer states, saturation and palette functions.
// ----------------------------------------------------------------------------
package mbet_pkg;

   // default build parameters
   localparam int MAX_ITER_DEF     = 80;
   localparam int FRAME_WIDTH_DEF  = 1920;
   localparam int FRAME_HEIGHT_DEF = 1080;

   // port widths
   localparam int PIX_W       = 11;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int COORD_W     = 32;
   localparam int STEP_W      = 25;
   localparam int RAD_W       = 31;
   localparam int COUNT_OUT_W = 7;
   localparam int COLOR_W     = 8;
   localparam int RGB_W       = 3 * COLOR_W;

   // datapath widths
   localparam int OFS_W  = 16;   // 2*index - frame, frame up to 8192
   localparam int PROD_W = 64;   // full signed 32x32 product
   localparam int HI_W   = 40;   // product after the Q24 floor shift
   localparam int WIDE_W = 42;   // sums ahead of saturation
   localparam int FRAC_W = 24;

   // register reset values
   localparam logic signed [COORD_W-1:0] CENTER_X_RST = -32'sd10066330;
   localparam logic signed [COORD_W-1:0] CENTER_Y_RST = 32'sd0;
   localparam logic [STEP_W-1:0]         STEP_RST     = 25'd23967;
   localparam logic [RAD_W-1:0]          RADIUS_RST   = 31'd1677721600;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X  = 2'd0,
      CSR_CENTER_Y  = 2'd1,
      CSR_PIX_STEP  = 2'd2,
      CSR_ESC_RAD2  = 2'd3
   } csr_index_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP_COL,
      ST_SETUP_ROW,
      ST_ITER_XX,
      ST_ITER_YY,
      ST_ITER_XY,
      ST_FINISH
   } state_type;

   // clamp a wide sum to signed 32 bits
   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(64'sd2147483647);
      lo = WIDE_W'(-64'sd2147483648);
      if (v > hi) begin
         sat32 = hi[COORD_W-1:0];
      end else if (v < lo) begin
         sat32 = lo[COORD_W-1:0];
      end else begin
         sat32 = v[COORD_W-1:0];
      end
   endfunction

   // ---- palette, evaluated at elaboration only ----

   localparam logic [63:0] Q28_ONE     = 64'd268435456;
   localparam logic [63:0] Q28_HALF_PI = 64'd421657428;

   // shift-subtract long division
   function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], a[i]};
         if (r >= b) begin
            r    = r - b;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // quarter-wave sine of num/den, Q28, odd Taylor series to x^9
   function automatic logic [63:0] quarter_sine(input logic [63:0] num,
                                                input logic [63:0] den);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] u;
      x  = udiv(num * Q28_HALF_PI, den);
      x2 = (x * x) >> 28;
      u  = Q28_ONE - x2 / 72;
      u  = Q28_ONE - ((x2 * u) >> 28) / 42;
      u  = Q28_ONE - ((x2 * u) >> 28) / 20;
      u  = Q28_ONE - ((x2 * u) >> 28) / 6;
      u  = (x * u) >> 28;
      if (u > Q28_ONE) begin
         u = Q28_ONE;
      end
      return u;
   endfunction

   // one channel for phase p in 1/(12*m) turn units
   function automatic logic [COLOR_W-1:0] wave_channel(input logic [63:0] p,
                                                       input logic [63:0] m);
      logic [63:0] full;
      logic [63:0] pm;
      logic [63:0] a;
      logic [63:0] quad;
      logic [63:0] rem;
      logic [63:0] s;
      logic [63:0] level;
      logic [63:0] scaled;
      full = 64'd12 * m;
      pm   = p - udiv(p, full) * full;
      a    = pm * 4;
      quad = udiv(a, full);
      rem  = a - quad * full;
      if (quad == 64'd0 || quad == 64'd2) begin
         s = quarter_sine(rem, full);
      end else begin
         s = quarter_sine(full - rem, full);
      end
      if (quad < 64'd2) begin
         level = Q28_ONE + s;
      end else begin
         level = Q28_ONE - s;
      end
      scaled = (level * 64'd255) >> 29;
      return scaled[COLOR_W-1:0];
   endfunction

   // packed {red, green, blue} for escape round n of m
   function automatic logic [RGB_W-1:0] pal_entry(input logic [63:0] n,
                                                  input logic [63:0] m);
      logic [COLOR_W-1:0] r;
      logic [COLOR_W-1:0] g;
      logic [COLOR_W-1:0] b;
      r = wave_channel(64'd24 * n + 64'd3 * m, m);
      g = wave_channel(64'd36 * n + 64'd2 * m, m);
      b = wave_channel(64'd48 * n, m);
      return {r, g, b};
   endfunction

endpackage

[rtl/mandelbrot_escape_time_pixel_core.sv]
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel core
// Maps a pixel to a point c, iterates z = z^2 + c in signed Q8.24 on one
// shared 32x32 multiplier and returns escape flag, round count and colour.
// ----------------------------------------------------------------------------
//
//   channel   ports                          handshake
//   -------   -----------------------------  -------------------------------
//   request   req_pixel_col, req_pixel_row   start high while busy low
//   response  rsp_escaped .. rsp_blue        rsp_valid strobe, one cycle
//   csr       csr_index, csr_wdata           csr_write_en, no wait
//
// One beat in, one beat out. The setup states SETUP_COL and SETUP_ROW form c on the
// multiplier, then each round steps through x*x, y*y and x*y on the one multiplier,
// and FINISH raises the registered result strobe. A point that has not escaped
// after MAX_ITER rounds is reported as bound.
// busy falls in the strobe cycle; a new start may be taken there.
// Synchronous reset returns the sequencer to idle and reloads the configuration registers.
// The receiver cannot stall: the result is offered for a single cycle.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_pixel_core_defines.svh"

module mandelbrot_escape_time_pixel_core #(
   parameter int MAX_ITER     = mbet_pkg::MAX_ITER_DEF,
   parameter int FRAME_WIDTH  = mbet_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = mbet_pkg::FRAME_HEIGHT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request
   input  logic                                 start,
   output logic                                 busy,
   input  logic [mbet_pkg::PIX_W-1:0]           req_pixel_col,
   input  logic [mbet_pkg::PIX_W-1:0]           req_pixel_row,
   // response
   output logic                                 rsp_valid,
   output logic                                 rsp_escaped,
   output logic [mbet_pkg::COUNT_OUT_W-1:0]     rsp_iter_count,
   output logic [mbet_pkg::COLOR_W-1:0]         rsp_red,
   output logic [mbet_pkg::COLOR_W-1:0]         rsp_green,
   output logic [mbet_pkg::COLOR_W-1:0]         rsp_blue,
   // configuration
   input  logic                                 csr_write_en,
   input  logic [mbet_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mbet_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import mbet_pkg::*;

   localparam int CNT_W     = $clog2(MAX_ITER + 1);
   localparam int IDX_W     = (MAX_ITER > 1) ? $clog2(MAX_ITER) : 1;
   localparam int PAL_DEPTH = 2 ** IDX_W;

   localparam logic signed [OFS_W-1:0] FRAME_W_S = OFS_W'(FRAME_WIDTH);
   localparam logic signed [OFS_W-1:0] FRAME_H_S = OFS_W'(FRAME_HEIGHT);
   localparam logic [CNT_W-1:0]        LAST_ITER = CNT_W'(MAX_ITER - 1);

   // configuration registers
   logic signed [COORD_W-1:0] center_x_ff;
   logic signed [COORD_W-1:0] center_y_ff;
   logic [STEP_W-1:0]         pixel_step_ff;
   logic [RAD_W-1:0]          esc_rad2_ff;

   // sequencer and datapath
   state_type                 state_ff, state_in;
   logic                      first_ff, first_in;
   logic                      esc_ff, esc_in;
   logic [CNT_W-1:0]          n_ff, n_in;
   logic signed [OFS_W-1:0]   dcol_ff, dcol_in;
   logic signed [OFS_W-1:0]   drow_ff, drow_in;
   logic signed [COORD_W-1:0] x_ff, x_in;
   logic signed [COORD_W-1:0] y_ff, y_in;
   logic signed [COORD_W-1:0] cx_ff, cx_in;
   logic signed [COORD_W-1:0] cy_ff, cy_in;
   logic signed [HI_W-1:0]    x2_ff, x2_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;

   // response registers
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_escaped_ff;
   logic [COUNT_OUT_W-1:0]    rsp_count_ff;
   logic [RGB_W-1:0]          rsp_rgb_ff, rsp_rgb_in;

   // shared multiplier operands
   logic signed [COORD_W-1:0] mul_a;
   logic signed [COORD_W-1:0] mul_b;

   logic signed [HI_W-1:0]     prod_hi;
   logic signed [WIDE_W-1:0]   half_ofs;
   logic signed [COORD_W-1:0]  col_coord;
   logic signed [COORD_W-1:0]  row_coord;
   logic signed [HI_W:0]       r2;
   logic                       escape_now;
   logic signed [COORD_W-1:0]  x_next;
   logic signed [COORD_W-1:0]  y_next;
   logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

   // palette table, built at elaboration
   logic [RGB_W-1:0] pal_rom [PAL_DEPTH];

   genvar gi;
   generate
      for (gi = 0; gi < PAL_DEPTH; gi++) begin : g_pal
         localparam logic [RGB_W-1:0] ENTRY =
            (gi < MAX_ITER) ? pal_entry(64'(gi), 64'(MAX_ITER)) : '0;
         assign pal_rom[gi] = ENTRY;
      end
   endgenerate

   // shared 32x32 signed multiplier, registered output
   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Q24 floor of the registered product
   assign prod_hi = prod_ff[PROD_W-1:FRAC_W];

   // pixel offset: floor of (2*index - frame) * step / 2
   assign half_ofs  = {prod_ff[WIDE_W-1], prod_ff[WIDE_W-1:1]};
   assign col_coord = sat32({{(WIDE_W-COORD_W){center_x_ff[COORD_W-1]}}, center_x_ff}
                            + half_ofs);
   assign row_coord = sat32({{(WIDE_W-COORD_W){center_y_ff[COORD_W-1]}}, center_y_ff}
                            + half_ofs);

   // escape test on x^2 + y^2, prod_hi holds y^2 here
   assign r2         = {prod_hi[HI_W-1], prod_hi} + {x2_ff[HI_W-1], x2_ff};
   assign escape_now = r2 > $signed({{(HI_W+1-RAD_W){1'b0}}, esc_rad2_ff});

   // next iterate, saturated
   assign x_next = sat32({{(WIDE_W-HI_W){x2_ff[HI_W-1]}}, x2_ff}
                         - {{(WIDE_W-HI_W){prod_hi[HI_W-1]}}, prod_hi}
                         + {{(WIDE_W-COORD_W){cx_ff[COORD_W-1]}}, cx_ff});
   assign y_next = sat32({prod_hi[HI_W-1], prod_hi, 1'b0}
                         + {{(WIDE_W-COORD_W){cy_ff[COORD_W-1]}}, cy_ff});

   // count masked to the port width
   assign count_ext = {{COUNT_OUT_W{1'b0}}, n_ff};

   // sequencer, operand select and next values
   always_comb begin
      state_in     = state_ff;
      first_in     = first_ff;
      esc_in       = esc_ff;
      n_in         = n_ff;
      dcol_in      = dcol_ff;
      drow_in      = drow_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      x2_in        = x2_ff;
      mul_a        = x_ff;
      mul_b        = y_ff;
      rsp_valid_in = 1'b0;
      rsp_rgb_in   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               dcol_in  = $signed({{(OFS_W-PIX_W-1){1'b0}}, req_pixel_col, 1'b0}) - FRAME_W_S;
               drow_in  = $signed({{(OFS_W-PIX_W-1){1'b0}}, req_pixel_row, 1'b0}) - FRAME_H_S;
               n_in     = '0;
               esc_in   = 1'b0;
               state_in = ST_SETUP_COL;
            end
         end
         ST_SETUP_COL: begin
            mul_a    = {{(COORD_W-OFS_W){dcol_ff[OFS_W-1]}}, dcol_ff};
            mul_b    = {{(COORD_W-STEP_W){1'b0}}, pixel_step_ff};
            state_in = ST_SETUP_ROW;
         end
         ST_SETUP_ROW: begin
            mul_a    = {{(COORD_W-OFS_W){drow_ff[OFS_W-1]}}, drow_ff};
            mul_b    = {{(COORD_W-STEP_W){1'b0}}, pixel_step_ff};
            cx_in    = col_coord;
            x_in     = col_coord;
            first_in = 1'b1;
            state_in = ST_ITER_XX;
         end
         ST_ITER_XX: begin
            // product register holds the row offset first, x*y afterwards
            mul_a    = x_ff;
            mul_b    = x_ff;
            first_in = 1'b0;
            if (first_ff) begin
               y_in  = row_coord;
               cy_in = row_coord;
            end else begin
               y_in  = y_next;
            end
            state_in = ST_ITER_YY;
         end
         ST_ITER_YY: begin
            mul_a    = y_ff;
            mul_b    = y_ff;
            x2_in    = prod_hi;
            state_in = ST_ITER_XY;
         end
         ST_ITER_XY: begin
            mul_a = x_ff;
            mul_b = y_ff;
            if (escape_now) begin
               esc_in   = 1'b1;
               state_in = ST_FINISH;
            end else begin
               x_in = x_next;
               n_in = n_ff + 1'b1;
               if (n_ff == LAST_ITER) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_ITER_XX;
               end
            end
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            if (esc_ff) begin
               rsp_rgb_in = pal_rom[n_ff[IDX_W-1:0]];
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         first_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         center_x_ff   <= CENTER_X_RST;
         center_y_ff   <= CENTER_Y_RST;
         pixel_step_ff <= STEP_RST;
         esc_rad2_ff   <= RADIUS_RST;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_CENTER_X: center_x_ff   <= csr_wdata;
               CSR_CENTER_Y: center_y_ff   <= csr_wdata;
               CSR_PIX_STEP: pixel_step_ff <= csr_wdata[STEP_W-1:0];
               CSR_ESC_RAD2: esc_rad2_ff   <= csr_wdata[RAD_W-1:0];
               default:      center_x_ff   <= center_x_ff;
            endcase
         end
      end
   end

   // datapath and response payload
   always_ff @(posedge clock) begin
      esc_ff  <= esc_in;
      n_ff    <= n_in;
      dcol_ff <= dcol_in;
      drow_ff <= drow_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      x2_ff   <= x2_in;
      prod_ff <= prod_in;
      if (rsp_valid_in) begin
         rsp_escaped_ff <= esc_ff;
         rsp_count_ff   <= count_ext[COUNT_OUT_W-1:0];
         rsp_rgb_ff     <= rsp_rgb_in;
      end
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_escaped    = rsp_escaped_ff;
   assign rsp_iter_count = rsp_count_ff;
   assign rsp_red        = rsp_rgb_ff[RGB_W-1 -: COLOR_W];
   assign rsp_green      = rsp_rgb_ff[COLOR_W +: COLOR_W];
   assign rsp_blue       = rsp_rgb_ff[COLOR_W-1:0];

   // checks
   `MBET_ASSERT_NEXT(a_accept_starts_setup, clock, reset, start && !busy,
      state_ff == ST_SETUP_COL, "accepted beat did not enter setup")
   `MBET_ASSERT_IMPL(a_strobe_when_idle, clock, reset, rsp_valid,
      state_ff == ST_IDLE, "result strobe outside idle")
   `MBET_ASSERT_IMPL(a_bound_is_black, clock, reset, rsp_valid && !rsp_escaped,
      rsp_red == '0 && rsp_green == '0 && rsp_blue == '0, "bound point not black")
   `MBET_ASSERT_IMPL(a_round_in_range, clock, reset,
      state_ff == ST_ITER_XX || state_ff == ST_ITER_YY || state_ff == ST_ITER_XY,
      n_ff < CNT_W'(MAX_ITER), "round counter past the limit")
   `MBET_ASSERT_IMPL(a_escape_round_in_range, clock, reset, state_ff == ST_FINISH && esc_ff,
      n_ff < CNT_W'(MAX_ITER), "escape round past the limit")

endmodule

[dv/mandelbrot_escape_time_pixel_core_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel core - result checker
// Watches the request, response and register ports. It keeps its own copy
// of the view registers, works out the escape flag, round count and colour
// for every accepted pixel, and compares each response beat in order.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_core_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic [mbet_pkg::PIX_W-1:0]          req_pixel_col,
   input  logic [mbet_pkg::PIX_W-1:0]          req_pixel_row,
   input  logic                                rsp_valid,
   input  logic                                rsp_escaped,
   input  logic [mbet_pkg::COUNT_OUT_W-1:0]    rsp_iter_count,
   input  logic [mbet_pkg::COLOR_W-1:0]        rsp_red,
   input  logic [mbet_pkg::COLOR_W-1:0]        rsp_green,
   input  logic [mbet_pkg::COLOR_W-1:0]        rsp_blue,
   input  logic                                csr_write_en,
   input  logic [mbet_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mbet_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int unsigned                         mismatch_count,
   output int unsigned                         pixels_in_flight,
   output int unsigned                         pixels_checked,
   output int unsigned                         pixels_escaped
);
   import mbet_pkg::*;

   localparam int ROUNDS    = MAX_ITER_DEF;
   localparam int WIDTH_PX  = FRAME_WIDTH_DEF;
   localparam int HEIGHT_PX = FRAME_HEIGHT_DEF;

   localparam logic [63:0] ONE_Q28     = 64'd268435456;
   localparam logic [63:0] HALF_PI_Q28 = 64'd421657428;

   typedef struct packed {
      logic                   escaped;
      logic [COUNT_OUT_W-1:0] iter_count;
      logic [COLOR_W-1:0]     red;
      logic [COLOR_W-1:0]     green;
      logic [COLOR_W-1:0]     blue;
   } pixel_verdict_type;

   typedef struct packed {
      logic [PIX_W-1:0]  col;
      logic [PIX_W-1:0]  row;
      pixel_verdict_type want;
   } pending_pixel_type;

   // view registers as the block should hold them
   longint view_cx;
   longint view_cy;
   longint view_step;
   longint view_rad2;

   pending_pixel_type expected_pixels[$];

   function automatic longint clamp_s32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // centre + floor((2*index - frame) * step / 2), saturated
   function automatic longint plane_coord(input longint centre,
                                          input logic [PIX_W-1:0] idx,
                                          input longint frame);
      longint offset2;
      offset2 = (2 * longint'(idx) - frame) * view_step;
      return clamp_s32(centre + (offset2 >>> 1));
   endfunction

   // Q28 sine of num/den of a quarter turn, odd series to x^9, truncated
   function automatic logic [63:0] quarter_sine_q28(input logic [63:0] num,
                                                    input logic [63:0] den);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] u;
      x  = (num * HALF_PI_Q28) / den;
      x2 = (x * x) >> 28;
      u  = ONE_Q28 - x2 / 72;
      u  = ONE_Q28 - ((x2 * u) >> 28) / 42;
      u  = ONE_Q28 - ((x2 * u) >> 28) / 20;
      u  = ONE_Q28 - ((x2 * u) >> 28) / 6;
      u  = (x * u) >> 28;
      if (u > ONE_Q28) u = ONE_Q28;
      return u;
   endfunction

   // colour level for a phase in 1/(12*ROUNDS) turn units
   function automatic logic [COLOR_W-1:0] channel_level(input logic [63:0] phase);
      logic [63:0] full;
      logic [63:0] a;
      logic [63:0] quad;
      logic [63:0] rem;
      logic [63:0] s;
      logic [63:0] level;
      full = 64'd12 * ROUNDS;
      a    = (phase % full) * 4;
      quad = a / full;
      rem  = a % full;
      if (quad == 64'd0 || quad == 64'd2) s = quarter_sine_q28(rem, full);
      else s = quarter_sine_q28(full - rem, full);
      level = (quad < 64'd2) ? ONE_Q28 + s : ONE_Q28 - s;
      return COLOR_W'((level * 64'd255) >> 29);
   endfunction

   // escape-time iteration of one pixel under the current view
   function automatic pixel_verdict_type escape_time_of(input logic [PIX_W-1:0] col,
                                                        input logic [PIX_W-1:0] row);
      longint            cx;
      longint            cy;
      longint            x;
      longint            y;
      longint            x2;
      longint            y2;
      longint            xy;
      int unsigned       rounds;
      logic              left;
      pixel_verdict_type v;
      cx     = plane_coord(view_cx, col, longint'(WIDTH_PX));
      cy     = plane_coord(view_cy, row, longint'(HEIGHT_PX));
      x      = cx;
      y      = cy;
      rounds = 0;
      left   = 1'b0;
      while (!left && rounds < ROUNDS) begin
         x2 = (x * x) >>> 24;
         y2 = (y * y) >>> 24;
         xy = (x * y) >>> 24;
         if (x2 + y2 > view_rad2) begin
            left = 1'b1;
         end else begin
            x = clamp_s32(x2 - y2 + cx);
            y = clamp_s32(2 * xy + cy);
            rounds++;
         end
      end
      v.escaped    = left;
      v.iter_count = COUNT_OUT_W'(rounds);
      if (left) begin
         v.red   = channel_level(64'(24 * rounds + 3 * ROUNDS));
         v.green = channel_level(64'(36 * rounds + 2 * ROUNDS));
         v.blue  = channel_level(64'(48 * rounds));
      end else begin
         v.red   = '0;
         v.green = '0;
         v.blue  = '0;
      end
      return v;
   endfunction

   initial begin
      mismatch_count   = 0;
      pixels_in_flight = 0;
      pixels_checked   = 0;
      pixels_escaped   = 0;
   end

   // sample every port on the rising edge
   always @(posedge clock) begin
      pending_pixel_type head;
      pixel_verdict_type got;
      if (reset) begin
         view_cx   = longint'(CENTER_X_RST);
         view_cy   = longint'(CENTER_Y_RST);
         view_step = longint'(STEP_RST);
         view_rad2 = longint'(RADIUS_RST);
         expected_pixels.delete();
      end else begin
         // response beat first, so a beat taken in the strobe cycle queues behind
         if (rsp_valid) begin
            got = {rsp_escaped, rsp_iter_count, rsp_red, rsp_green, rsp_blue};
            pixels_checked++;
            if (rsp_escaped) pixels_escaped++;
            if (expected_pixels.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: response beat with no pixel outstanding", $realtime);
            end else begin
               head = expected_pixels.pop_front();
               if (got.escaped !== head.want.escaped ||
                   got.iter_count !== head.want.iter_count ||
                   got.red !== head.want.red || got.green !== head.want.green ||
                   got.blue !== head.want.blue) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: pixel (%0d,%0d) expected esc %0b n %0d rgb %h %h %h,%s",
                              $realtime, head.col, head.row, head.want.escaped,
                              head.want.iter_count, head.want.red, head.want.green,
                              head.want.blue,
                              $sformatf(" got esc %0b n %0d rgb %h %h %h", got.escaped,
                                        got.iter_count, got.red, got.green, got.blue));
               end
            end
         end
         if (start && !busy) begin
            head.col  = req_pixel_col;
            head.row  = req_pixel_row;
            head.want = escape_time_of(req_pixel_col, req_pixel_row);
            expected_pixels.push_back(head);
         end
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_CENTER_X: view_cx = longint'(signed'(csr_wdata));
               CSR_CENTER_Y: view_cy = longint'(signed'(csr_wdata));
               CSR_PIX_STEP: view_step = longint'(csr_wdata[STEP_W-1:0]);
               CSR_ESC_RAD2: view_rad2 = longint'(csr_wdata[RAD_W-1:0]);
               default: ;
            endcase
         end
      end
      pixels_in_flight = expected_pixels.size();
   end

endmodule

[dv/mandelbrot_escape_time_pixel_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel core - testbench top
// Drives pixel requests and view register writes: a directed set of frame
// corners, out-of-frame indices, zero and full-scale steps, saturating and
// zero-radius views, then random views with mostly in-frame pixels.
// The checker beside the core predicts and compares every response beat.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_core_test;
   import mbet_pkg::*;

   localparam logic [31:0] Q24_FOUR = 32'd67108864;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [PIX_W-1:0]       req_pixel_col;
   logic [PIX_W-1:0]       req_pixel_row;
   logic                   rsp_valid;
   logic                   rsp_escaped;
   logic [COUNT_OUT_W-1:0] rsp_iter_count;
   logic [COLOR_W-1:0]     rsp_red;
   logic [COLOR_W-1:0]     rsp_green;
   logic [COLOR_W-1:0]     rsp_blue;
   logic                   csr_write_en;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int unsigned mismatch_count;
   int unsigned pixels_in_flight;
   int unsigned pixels_checked;
   int unsigned pixels_escaped;

   int unsigned idle_max;
   int unsigned views_set;
   int unsigned csr_writes;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   mandelbrot_escape_time_pixel_core DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_pixel_col  (req_pixel_col),
      .req_pixel_row  (req_pixel_row),
      .rsp_valid      (rsp_valid),
      .rsp_escaped    (rsp_escaped),
      .rsp_iter_count (rsp_iter_count),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   mandelbrot_escape_time_pixel_core_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_pixel_col    (req_pixel_col),
      .req_pixel_row    (req_pixel_row),
      .rsp_valid        (rsp_valid),
      .rsp_escaped      (rsp_escaped),
      .rsp_iter_count   (rsp_iter_count),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .pixels_in_flight (pixels_in_flight),
      .pixels_checked   (pixels_checked),
      .pixels_escaped   (pixels_escaped)
   );

   // one register write, then a quiet gap with write enable low
   task automatic write_csr(input csr_index_type idx, input logic [31:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
      csr_writes++;
   endtask

   // hold off new pixels until every response beat is back
   task automatic drain_pixels();
      start <= 1'b0;
      while (pixels_in_flight != 0) @(negedge clock);
   endtask

   task automatic set_view(input logic [31:0] cx, input logic [31:0] cy,
                           input logic [31:0] step, input logic [31:0] rad2);
      drain_pixels();
      write_csr(CSR_CENTER_X, cx);
      write_csr(CSR_CENTER_Y, cy);
      write_csr(CSR_PIX_STEP, step);
      write_csr(CSR_ESC_RAD2, rad2);
      views_set++;
   endtask

   // one request beat; returns on the falling edge after it was taken
   task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
      int unsigned gap;
      gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start         <= 1'b1;
      req_pixel_col <= col;
      req_pixel_row <= row;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // random view: mostly near the set, some deep zooms, extremes and noise
   task automatic random_view();
      int unsigned  kind;
      logic [31:0]  cx;
      logic [31:0]  cy;
      logic [31:0]  step;
      logic [31:0]  rad2;
      logic [31:0]  corner[3];
      corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
      kind   = $urandom_range(0, 9);
      case (kind)
         6: begin
            cx   = CENTER_X_RST;
            cy   = CENTER_Y_RST;
            step = 32'(STEP_RST);
            rad2 = 32'(RADIUS_RST);
         end
         7: begin
            cx   = $urandom;
            cy   = $urandom;
            step = $urandom;
            rad2 = $urandom;
         end
         8: begin
            cx   = corner[$urandom_range(0, 2)];
            cy   = corner[$urandom_range(0, 2)];
            case ($urandom_range(0, 2))
               0: step = 32'd0;
               1: step = 32'd1;
               default: step = 32'hFFFF_FFFF;
            endcase
            rad2 = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'd0;
         end
         9: begin
            // deep zoom on the seahorse valley
            cx   = -32'sd12499026 + $urandom_range(0, 2000) - 1000;
            cy   = 32'd1677722 + $urandom_range(0, 2000) - 1000;
            step = $urandom_range(1, 256);
            rad2 = Q24_FOUR;
         end
         default: begin
            cx   = $urandom_range(0, 50331648) - 36909875;
            cy   = $urandom_range(0, 40265318) - 20132659;
            step = $urandom_range(1, 60000);
            case ($urandom_range(0, 2))
               0: rad2 = Q24_FOUR;
               1: rad2 = 32'(RADIUS_RST);
               default: rad2 = $urandom_range(0, 32'h7FFF_FFFF);
            endcase
         end
      endcase
      // bits above each register's width are don't-care to the core
      if (kind != 8) begin
         step[31:STEP_W] = (32 - STEP_W)'($urandom_range(0, 127));
         rad2[31]        = 1'($urandom_range(0, 1));
      end
      set_view(cx, cy, step, rad2);
   endtask

   // safety net against a hung handshake
   initial begin
      #8_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      logic [PIX_W-1:0] edge_col[10];
      logic [PIX_W-1:0] edge_row[10];
      logic [PIX_W-1:0] col;
      logic [PIX_W-1:0] row;
      edge_col = '{0, 1919, 960, 2047, 0, 2047, 1919, 0, 700, 1500};
      edge_row = '{0, 1079, 540, 2047, 2047, 0, 0, 1079, 540, 300};
      reset         = 1'b1;
      start         = 1'b0;
      req_pixel_col = '0;
      req_pixel_row = '0;
      csr_write_en  = 1'b0;
      csr_index     = CSR_CENTER_X;
      csr_wdata     = '0;
      idle_max      = 0;
      views_set     = 1;
      csr_writes    = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // reset view: frame corners, centre and indices past the frame
      for (int i = 0; i < 10; i++) send_pixel(edge_col[i], edge_row[i]);

      // zero step: every pixel lands on the centre
      set_view(32'd0, 32'd0, 32'd0, 32'(RADIUS_RST));
      send_pixel(11'd0, 11'd2047);
      set_view(-32'sd33554432, 32'd0, 32'd0, 32'(RADIUS_RST));
      send_pixel(11'd5, 11'd5);
      // zero radius: escapes at once unless x^2 + y^2 floors to zero, as at the origin
      set_view(32'd4194304, 32'd0, 32'd0, 32'd0);
      send_pixel(11'd100, 11'd100);
      set_view(32'd0, 32'd0, 32'd0, 32'd0);
      send_pixel(11'd100, 11'd100);
      // widest radius with points whose next iterate saturates
      set_view(32'd189792256, 32'd0, 32'd0, 32'h7FFF_FFFF);
      send_pixel(11'd7, 11'd9);
      set_view(32'd132539597, 32'd132539597, 32'd0, 32'h7FFF_FFFF);
      send_pixel(11'd7, 11'd9);
      set_view(32'd132539597, -32'sd132539597, 32'd0, 32'h7FFF_FFFF);
      send_pixel(11'd7, 11'd9);
      // full-scale step with centres at the rails: the point saturates
      set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pixel(11'd0, 11'd0);
      send_pixel(11'd2047, 11'd2047);

      // random views, each with a run of pixels
      for (int v = 0; v < 14; v++) begin
         random_view();
         idle_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
         repeat (100) begin
            if ($urandom_range(0, 63) == 0) drain_pixels();
            if ($urandom_range(0, 6) == 0) begin
               col = PIX_W'($urandom_range(0, 2047));
               row = PIX_W'($urandom_range(0, 2047));
            end else begin
               col = PIX_W'($urandom_range(0, FRAME_WIDTH_DEF - 1));
               row = PIX_W'($urandom_range(0, FRAME_HEIGHT_DEF - 1));
            end
            send_pixel(col, row);
         end
      end

      drain_pixels();
      repeat (260) @(negedge clock);

      $display("Covered %0d pixels over %0d view settings, %0d register writes.",
               pixels_checked, views_set, csr_writes);
      $display("%0d pixels escaped, %0d stayed bound, %0d mismatches.",
               pixels_escaped, pixels_checked - pixels_escaped, mismatch_count);
      if (mismatch_count == 0 && pixels_in_flight == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
